>>> design/ncl_pkg.sv
// ----------------------------------------------------------------------------
// ncl_pkg: shared types and constants of the nearest centroid labeler
// Field widths, operation codes, register indexes and the record that moves
// from one cluster cell to the next along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ncl_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIM_DEF      = 32;
  localparam int FEATURE_BITS_DEF = 16;

  localparam int CLUSTER_W    = 4;
  localparam int ELEM_W       = 5;
  localparam int VALUE_W      = 16;
  localparam int LABEL_W      = 4;
  localparam int CFG_W        = 5;
  localparam int SUM_W        = 40;
  localparam int DIFF_LIMIT_W = 20;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [SUM_W-1:0] SUM_MAX          = {SUM_W{1'b1}};
  localparam logic [CFG_W-1:0] NUM_CLUSTERS_RST = CFG_W'(10);

  typedef enum logic {
    OP_CENTROID = 1'b0,
    OP_FEATURE  = 1'b1
  } op_t;

  typedef enum logic {
    REG_NUM_CLUSTERS = 1'b0
  } reg_idx_t;

  typedef struct packed {
    op_t                  op;
    logic [CLUSTER_W-1:0] cluster_index;
    logic [ELEM_W-1:0]    element_index;
    logic [VALUE_W-1:0]   element_value;
    logic                 last_element;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   min_sum;
    logic [LABEL_W-1:0] label;
  } best_t;

  typedef struct packed {
    logic  valid;
    item_t item;
    best_t best;
  } link_t;

endpackage

`default_nettype wire

>>> design/ncl_ram.sv
// ----------------------------------------------------------------------------
// ncl_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/ncl_cell.sv
// ----------------------------------------------------------------------------
// ncl_cell: one cluster of the labeling chain
// Holds the centroid of one cluster and its running distance sum. Each
// transaction passes through four stages: centroid read, absolute difference,
// square, and saturating accumulate with the running minimum handed onwards.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_cell #(
  parameter int CELL_ID      = 0,
  parameter int MAX_DIM      = 32,
  parameter int FEATURE_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv_i,
  input  wire logic           en_i,
  input  wire ncl_pkg::link_t link_i,
  output ncl_pkg::link_t      link_o
);

  import ncl_pkg::*;

  localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = FEATURE_BITS + 1;
  localparam int EXT_W = (DW > DIFF_LIMIT_W) ? DW : DIFF_LIMIT_W + 1;

  logic                    in_rng;
  logic                    wr_en;
  logic [FEATURE_BITS-1:0] rd_data;

  link_t                   s1_r;
  logic                    s1_rng_r;
  link_t                   s2_r;
  logic                    s2_rng_r;
  logic [DIFF_LIMIT_W-1:0] s2_ad_r;
  logic                    s2_big_r;
  link_t                   s3_r;
  logic                    s3_rng_r;
  logic [SUM_W-1:0]        s3_sq_r;
  logic                    s3_big_r;
  link_t                   link_r;
  link_t                   link_nxt;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_nxt;

  logic signed [FEATURE_BITS-1:0] feat;
  logic signed [FEATURE_BITS-1:0] cent;
  logic signed [DW-1:0]           diff;
  logic        [DW-1:0]           ad;
  logic        [EXT_W-1:0]        ad_ext;
  logic                           big_nxt;
  logic        [2*DIFF_LIMIT_W-1:0] sq_full;
  logic        [SUM_W-1:0]        sq_nxt;
  logic        [SUM_W:0]          tot;
  logic        [SUM_W-1:0]        acc_sum;
  logic        [SUM_W-1:0]        new_sum;
  logic                           is_feat;
  logic                           add_en;
  logic                           take;

  assign in_rng = 32'(link_i.item.element_index) < 32'(MAX_DIM);
  assign wr_en  = adv_i && link_i.valid && (link_i.item.op == OP_CENTROID) && in_rng &&
                  (32'(link_i.item.cluster_index) == 32'(CELL_ID));

  ncl_ram #(
    .WIDTH (FEATURE_BITS),
    .DEPTH (MAX_DIM)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (AW'(link_i.item.element_index)),
    .wdata   (FEATURE_BITS'(link_i.item.element_value)),
    .re      (adv_i),
    .raddr   (AW'(link_i.item.element_index)),
    .rdata_r (rd_data)
  );

  always_comb begin
    feat    = FEATURE_BITS'(s1_r.item.element_value);
    cent    = rd_data;
    diff    = DW'(feat) - DW'(cent);
    ad      = diff[DW-1] ? DW'(-diff) : DW'(diff);
    ad_ext  = EXT_W'(ad);
    big_nxt = ad_ext > EXT_W'({DIFF_LIMIT_W{1'b1}});
  end

  assign sq_full = s2_ad_r * s2_ad_r;
  assign sq_nxt  = SUM_W'(sq_full);

  always_comb begin
    tot     = {1'b0, sum_r} + {1'b0, s3_sq_r};
    acc_sum = (s3_big_r || (tot >= {1'b0, SUM_MAX})) ? SUM_MAX : tot[SUM_W-1:0];
    is_feat = s3_r.valid && (s3_r.item.op == OP_FEATURE);
    add_en  = is_feat && en_i && s3_rng_r;
    new_sum = add_en ? acc_sum : sum_r;
    take    = en_i && ((CELL_ID == 0) || (new_sum < s3_r.best.min_sum));
    link_nxt = s3_r;
    if (take) begin
      link_nxt.best.min_sum = new_sum;
      link_nxt.best.label   = LABEL_W'(CELL_ID);
    end
    if (is_feat && s3_r.item.last_element) begin
      sum_nxt = '0;
    end else begin
      sum_nxt = new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid   <= 1'b0;
      s2_r.valid   <= 1'b0;
      s3_r.valid   <= 1'b0;
      link_r.valid <= 1'b0;
      sum_r        <= '0;
    end else if (adv_i) begin
      s1_r     <= link_i;
      s1_rng_r <= in_rng;
      s2_r     <= s1_r;
      s2_rng_r <= s1_rng_r;
      s2_ad_r  <= ad_ext[DIFF_LIMIT_W-1:0];
      s2_big_r <= big_nxt;
      s3_r     <= s2_r;
      s3_rng_r <= s2_rng_r;
      s3_sq_r  <= sq_nxt;
      s3_big_r <= s2_big_r;
      link_r   <= link_nxt;
      sum_r    <= sum_nxt;
    end
  end

  assign link_o = link_r;

  // A sum only grows between two vector ends.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && is_feat && !s3_r.item.last_element) |=> (sum_r >= $past(sum_r)))
    else $error("distance sum decreased within a vector");

  // The end of a vector leaves the sum cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv_i && is_feat && s3_r.item.last_element) |=> (sum_r == '0))
    else $error("distance sum not cleared after the last element");

  // A saturated sum stays saturated until the vector ends.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((sum_r == SUM_MAX) && !(adv_i && is_feat && s3_r.item.last_element))
      |=> (sum_r == SUM_MAX))
    else $error("saturated distance sum left saturation");

endmodule

`default_nettype wire

>>> design/nearest_centroid_labeler_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_labeler_top: nearest centroid labeler
// Channel  Direction  Transaction
// in_      slave      one centroid write or one feature element
// out_     master     label of the nearest enabled centroid
// cfg_     APB slave  num_clusters at byte address 0
//
// A chain of MAX_CLUSTERS cells, each with four stages, takes one transaction
// per cycle unless stalled, and registers each label at its output. The single
// output register sets the stall: while a label waits, the whole chain and
// in_tready hold. Reset clears the sums and all valid flags at once; centroid
// memories are not cleared and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centroid_labeler_top #(
  parameter int MAX_CLUSTERS = ncl_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIM      = ncl_pkg::MAX_DIM_DEF,
  parameter int FEATURE_BITS = ncl_pkg::FEATURE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // cluster_index[3:0], element_index[8:4], element_value[24:9]
  input  wire logic [ncl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation
  input  wire logic                             in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // label[3:0]
  output logic      [ncl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [ncl_pkg::APB_AW-1:0]       cfg_paddr,
  input  wire logic [ncl_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic      [ncl_pkg::APB_DW-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  import ncl_pkg::*;

  logic                  adv;
  logic [CFG_W-1:0]      num_r;
  logic                  cfg_wr;
  logic [MAX_CLUSTERS-1:0] en;
  link_t                 chain [MAX_CLUSTERS+1];
  link_t                 tail;
  logic                  tail_done;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [LABEL_W-1:0]    out_label_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_NUM_CLUSTERS);
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_CLUSTERS) ? APB_DW'(num_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= NUM_CLUSTERS_RST;
    end else if (cfg_wr) begin
      num_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && rst_n;

  always_comb begin
    chain[0]                    = '0;
    chain[0].valid              = in_tvalid && in_tready;
    chain[0].item.op            = op_t'(in_tuser);
    chain[0].item.cluster_index = in_tdata[3:0];
    chain[0].item.element_index = in_tdata[8:4];
    chain[0].item.element_value = in_tdata[24:9];
    chain[0].item.last_element  = in_tlast;
  end

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    assign en[g] = (g == 0) || (32'(num_r) > 32'(g));

    ncl_cell #(
      .CELL_ID      (g),
      .MAX_DIM      (MAX_DIM),
      .FEATURE_BITS (FEATURE_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv_i  (adv),
      .en_i   (en[g]),
      .link_i (chain[g]),
      .link_o (chain[g+1])
    );
  end

  assign tail          = chain[MAX_CLUSTERS];
  assign tail_done     = tail.valid && (tail.item.op == OP_FEATURE) && tail.item.last_element;
  assign out_valid_nxt = adv ? tail_done : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_label_r <= tail.best.label;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_label_r);

  // A label only appears behind the last element of a feature vector.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tail_done))
    else $error("label raised without a finished vector");

  // While a label waits, the end of the chain holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tail))
    else $error("chain moved during a stall");

  // A register write lands in num_clusters.
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (num_r == $past(cfg_pwdata[CFG_W-1:0])))
    else $error("num_clusters write lost");

endmodule

`default_nettype wire
